// ----- design/bb3e_pkg.sv -----
`timescale 1ns / 1ps

package bb3e_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_W      = 11;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t REG_IMAGE_WIDTH  = 1'b0;
    localparam cfg_idx_t REG_IMAGE_HEIGHT = 1'b1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        pix_t older;
        pix_t newer;
    } line_pair_t;

    typedef struct packed {
        logic col_left;
        logic col_right;
        logic row_top;
        logic row_bottom;
        logic frame_end;
    } nb_flags_t;

    localparam int SUM_W      = 12;
    localparam int MUL_W      = 17;
    localparam int DIV_SHIFT  = 16;
    localparam logic [MUL_W-1:0] MUL_ONE   = 17'd65536;
    localparam logic [MUL_W-1:0] MUL_THIRD = 17'd21846;
    localparam logic [MUL_W-1:0] MUL_NINTH = 17'd7282;

    typedef struct packed {
        logic [2:0]       half;
        logic [1:0]       shift;
        logic [MUL_W-1:0] mul;
    } div_plan_t;

endpackage

// ----- design/bb3e_if.sv -----
`timescale 1ns / 1ps

interface bb3e_pix_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output req_type, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink (input valid, input req_type, input in_red, input in_green,
                  input in_blue, output ready);
endinterface

interface bb3e_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_end, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input frame_end, output ready);
endinterface

interface bb3e_cfg_if;
    import bb3e_pkg::*;
    logic             valid;
    logic             ready;
    cfg_idx_t         index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/bb3e_line_buf.sv -----
`timescale 1ns / 1ps

module bb3e_line_buf #(
    parameter int DEPTH = bb3e_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output bb3e_pkg::line_pair_t     rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  bb3e_pkg::line_pair_t     wr_data
);
    import bb3e_pkg::*;

    line_pair_t mem [DEPTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/box_blur_3x3_edge_aware.sv -----
// Edge-aware 3x3 box blur over an RGB raster stream, one request per clock unless stalled.
// A result passes through stage registers A, B, C and the output register after the
// request that releases it, width+1 slots after its pixel; one per cycle without stalls.
// The four stages are line buffer read, window shift, masked sum, and reciprocal divide.
// Reset clears the slot counters and pipeline valids and sets the size to 640 x 480.
// Line buffers are not cleared; entries outside the image are never summed.
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH  = bb3e_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3e_pkg::MAX_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bb3e_cfg_if.sink   cfg,
    bb3e_pix_if.sink   pixels,
    bb3e_res_if.source results
);
    import bb3e_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT + 2);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int WIDTH_INIT  = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
    localparam int HEIGHT_INIT = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;

    function automatic div_plan_t div_plan(input logic [1:0] ncols, input logic [1:0] nrows);
        div_plan_t p;
        case ({ncols, nrows})
            {2'd1, 2'd1}:               p = '{half: 3'd0, shift: 2'd0, mul: MUL_ONE};
            {2'd1, 2'd2}, {2'd2, 2'd1}: p = '{half: 3'd1, shift: 2'd1, mul: MUL_ONE};
            {2'd2, 2'd2}:               p = '{half: 3'd2, shift: 2'd2, mul: MUL_ONE};
            {2'd1, 2'd3}, {2'd3, 2'd1}: p = '{half: 3'd1, shift: 2'd0, mul: MUL_THIRD};
            {2'd2, 2'd3}, {2'd3, 2'd2}: p = '{half: 3'd3, shift: 2'd1, mul: MUL_THIRD};
            {2'd3, 2'd3}:               p = '{half: 3'd4, shift: 2'd0, mul: MUL_NINTH};
            default:                    p = '{half: 3'd0, shift: 2'd0, mul: MUL_ONE};
        endcase
        return p;
    endfunction

    function automatic logic [7:0] mean_div(input logic [SUM_W-1:0] x, input div_plan_t p);
        logic [SUM_W+MUL_W-1:0] prod;
        prod = (SUM_W + MUL_W)'(x >> p.shift) * (SUM_W + MUL_W)'(p.mul);
        return prod[DIV_SHIFT +: 8];
    endfunction

    // Configuration and slot counters
    logic [WW-1:0] width_reg, width_cfg;
    logic [HW-1:0] height_reg, height_cfg;
    logic [XW-1:0] in_col_reg, in_col_next, emit_col_reg, emit_col_next;
    logic [YW-1:0] in_row_reg, in_row_next, emit_row_reg, emit_row_next;
    logic          cfg_take, pix_take, slot_take;
    logic          drain_slot, emitting, last_slot, in_col_wrap, emit_col_wrap;
    nb_flags_t     flags;
    pix_t          in_px;

    // Pipeline control
    logic o_ld, c_ld, b_ld, a_ld, a_leave;

    // Stage A: line buffer read in flight
    logic       a_valid_reg;
    pix_t       a_px_reg;
    logic [XW-1:0] a_addr_reg;
    logic       a_emit_reg;
    nb_flags_t  a_flags_reg;
    logic       a_byp_reg;
    pix_t       a_byp_top_reg, a_byp_mid_reg;
    line_pair_t rd_pair, wr_pair;
    pix_t       a_top, a_mid;

    // Stage B: neighborhood window
    logic      b_valid_reg;
    nb_flags_t b_flags_reg;
    pix_t      win_reg [3][3];
    logic [2:0] colok, rowok;
    logic [1:0] ncols, nrows;
    div_plan_t  plan;
    logic [SUM_W-1:0] sum_red, sum_green, sum_blue;

    // Stage C: biased sums
    logic             c_valid_reg;
    logic [SUM_W-1:0] c_red_reg, c_green_reg, c_blue_reg;
    div_plan_t        c_plan_reg;
    logic             c_fe_reg;

    // Output register
    logic       o_valid_reg;
    logic [7:0] o_red_reg, o_green_reg, o_blue_reg;
    logic       o_fe_reg;

    always_comb
    begin
        cfg_take = cfg.valid && cfg.ready;
        if (cfg.data == '0)
        begin
            width_cfg = WW'(1);
        end
        else if (int'(cfg.data) > MAX_WIDTH)
        begin
            width_cfg = WW'(MAX_WIDTH);
        end
        else
        begin
            width_cfg = WW'(cfg.data);
        end
        if (cfg.data == '0)
        begin
            height_cfg = HW'(1);
        end
        else if (int'(cfg.data) > MAX_HEIGHT)
        begin
            height_cfg = HW'(MAX_HEIGHT);
        end
        else
        begin
            height_cfg = HW'(cfg.data);
        end
    end

    assign cfg.ready = 1'b1;

    always_comb
    begin
        o_ld    = !o_valid_reg || results.ready;
        c_ld    = !c_valid_reg || o_ld;
        b_ld    = !b_valid_reg || c_ld;
        a_ld    = !a_valid_reg || b_ld;
        a_leave = a_valid_reg && b_ld;
    end

    assign pixels.ready = a_ld;

    always_comb
    begin
        pix_take   = pixels.valid && pixels.ready;
        drain_slot = in_row_reg >= YW'(height_reg);
        slot_take  = pix_take && ((pixels.req_type == REQ_DRAIN) == drain_slot);
        emitting   = (in_row_reg >= YW'(2)) || (in_row_reg == YW'(1) && in_col_reg != '0);
        last_slot  = in_row_reg == (YW'(height_reg) + YW'(1));
        in_col_wrap   = (int'(in_col_reg) + 1) >= int'(width_reg);
        emit_col_wrap = (int'(emit_col_reg) + 1) >= int'(width_reg);

        flags.col_left   = emit_col_reg != '0;
        flags.col_right  = !emit_col_wrap;
        flags.row_top    = emit_row_reg != '0;
        flags.row_bottom = (int'(emit_row_reg) + 1) < int'(height_reg);
        flags.frame_end  = ((int'(emit_row_reg) + 1) == int'(height_reg)) && emit_col_wrap;

        if (pixels.req_type == REQ_DRAIN)
        begin
            in_px = '0;
        end
        else
        begin
            in_px = '{red: pixels.in_red, green: pixels.in_green, blue: pixels.in_blue};
        end

        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        emit_col_next = emit_col_reg;
        emit_row_next = emit_row_reg;
        if (slot_take)
        begin
            if (in_col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + YW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + XW'(1);
            end
            if (emitting)
            begin
                if (emit_col_wrap)
                begin
                    emit_col_next = '0;
                    emit_row_next = emit_row_reg + YW'(1);
                end
                else
                begin
                    emit_col_next = emit_col_reg + XW'(1);
                end
            end
            if (last_slot)
            begin
                in_col_next   = '0;
                in_row_next   = '0;
                emit_col_next = '0;
                emit_row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WW'(WIDTH_INIT);
            height_reg   <= HW'(HEIGHT_INIT);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
        end
        else if (cfg_take)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:  width_reg  <= width_cfg;
                REG_IMAGE_HEIGHT: height_reg <= height_cfg;
                default:          ;
            endcase
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            emit_col_reg <= emit_col_next;
            emit_row_reg <= emit_row_next;
        end
    end

    // The request leaving stage A writes its column at the same edge that the next
    // request reads; when both hit the same column the written values are forwarded.
    always_comb
    begin
        a_top   = a_byp_reg ? a_byp_top_reg : rd_pair.older;
        a_mid   = a_byp_reg ? a_byp_mid_reg : rd_pair.newer;
        wr_pair = '{older: a_mid, newer: a_px_reg};
    end

    bb3e_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (slot_take),
        .rd_addr (in_col_reg),
        .rd_data (rd_pair),
        .wr_en   (a_leave),
        .wr_addr (a_addr_reg),
        .wr_data (wr_pair)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ld)
        begin
            a_valid_reg <= slot_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_take)
        begin
            a_px_reg      <= in_px;
            a_addr_reg    <= in_col_reg;
            a_emit_reg    <= emitting;
            a_flags_reg   <= flags;
            a_byp_reg     <= a_valid_reg && (a_addr_reg == in_col_reg);
            a_byp_top_reg <= a_mid;
            a_byp_mid_reg <= a_px_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ld)
        begin
            b_valid_reg <= a_leave && a_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_leave)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[0][i] <= win_reg[1][i];
                win_reg[1][i] <= win_reg[2][i];
            end
            win_reg[2][0] <= a_top;
            win_reg[2][1] <= a_mid;
            win_reg[2][2] <= a_px_reg;
            b_flags_reg   <= a_flags_reg;
        end
    end

    // The sum is biased by half the divisor so that the divide rounds half up.
    always_comb
    begin
        colok = {b_flags_reg.col_right, 1'b1, b_flags_reg.col_left};
        rowok = {b_flags_reg.row_bottom, 1'b1, b_flags_reg.row_top};
        ncols = 2'd1 + {1'b0, b_flags_reg.col_left} + {1'b0, b_flags_reg.col_right};
        nrows = 2'd1 + {1'b0, b_flags_reg.row_top} + {1'b0, b_flags_reg.row_bottom};
        plan  = div_plan(ncols, nrows);
        sum_red   = SUM_W'(plan.half);
        sum_green = SUM_W'(plan.half);
        sum_blue  = SUM_W'(plan.half);
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (colok[j] && rowok[i])
                begin
                    sum_red   = sum_red + SUM_W'(win_reg[j][i].red);
                    sum_green = sum_green + SUM_W'(win_reg[j][i].green);
                    sum_blue  = sum_blue + SUM_W'(win_reg[j][i].blue);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ld)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ld && b_valid_reg)
        begin
            c_red_reg   <= sum_red;
            c_green_reg <= sum_green;
            c_blue_reg  <= sum_blue;
            c_plan_reg  <= plan;
            c_fe_reg    <= b_flags_reg.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ld)
        begin
            o_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ld && c_valid_reg)
        begin
            o_red_reg   <= mean_div(c_red_reg, c_plan_reg);
            o_green_reg <= mean_div(c_green_reg, c_plan_reg);
            o_blue_reg  <= mean_div(c_blue_reg, c_plan_reg);
            o_fe_reg    <= c_fe_reg;
        end
    end

    assign results.valid     = o_valid_reg;
    assign results.out_red   = o_red_reg;
    assign results.out_green = o_green_reg;
    assign results.out_blue  = o_blue_reg;
    assign results.frame_end = o_fe_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        int'(in_col_reg) < int'(width_reg))
        else $error("Input column reached the image width.");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit_row_reg <= in_row_reg)
        else $error("Output row ran ahead of the input row.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pix_take && !slot_take && !cfg_take
        |=> $stable(in_col_reg) && $stable(in_row_reg) && !a_valid_reg)
        else $error("An ignored request changed the slot position or entered the pipeline.");

endmodule

// ----- sim/box_blur_3x3_edge_aware_tb.sv -----
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware_tb;
    import bb3e_pkg::*;

    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 620;
    localparam int EXTREME_SLOTS = 40;

    typedef struct packed {
        pix_t color;
        logic frame_end;
    } blur_out_t;

    class blur_scoreboard;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        pix_t             older_row [MAX_WIDTH_DEF];
        pix_t             newer_row [MAX_WIDTH_DEF];
        pix_t             win_px [3][3];
        int               in_col;
        int               in_row;
        int               out_col;
        int               out_row;
        int               errors;
        blur_out_t        expected_pixels [$];

        function new();
            width_reg = CFG_W'(WIDTH_RST);
            height_reg = CFG_W'(HEIGHT_RST);
            foreach (older_row[i])
            begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            errors = 0;
            clear_position();
        endfunction

        function void clear_position();
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            foreach (win_px[j, i])
                win_px[j][i] = '0;
        endfunction

        function int clamp_dim(int v, int max_v);
            if (v < 1)
                return 1;
            if (v > max_v)
                return max_v;
            return v;
        endfunction

        function int used_width();
            return clamp_dim(int'(width_reg), MAX_WIDTH_DEF);
        endfunction

        function int used_height();
            return clamp_dim(int'(height_reg), MAX_HEIGHT_DEF);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = value;
            else
                height_reg = value;
            clear_position();
        endfunction

        function logic [7:0] channel_mean(int shift, logic [2:0] col_ok, logic [2:0] row_ok);
            int sum;
            int n;
            sum = 0;
            n = 0;
            for (int j = 0; j < 3; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (col_ok[j] && row_ok[i])
                    begin
                        sum += int'((win_px[j][i] >> shift) & 24'hFF);
                        n++;
                    end
                end
            end
            return 8'((2 * sum + n) / (2 * n));
        endfunction

        function void note_request(logic kind, pix_t p);
            int        w;
            int        h;
            int        c;
            logic      emitting;
            logic      last_slot;
            pix_t      top;
            pix_t      mid;
            pix_t      px;
            logic [2:0] col_ok;
            logic [2:0] row_ok;
            blur_out_t res;
            w = used_width();
            h = used_height();
            if ((kind == REQ_DRAIN) != (in_row >= h))
                return;
            c = (in_col >= MAX_WIDTH_DEF) ? 0 : in_col;
            px = (kind == REQ_DRAIN) ? pix_t'('0) : p;
            top = older_row[c];
            mid = newer_row[c];
            older_row[c] = mid;
            newer_row[c] = px;
            win_px[0] = win_px[1];
            win_px[1] = win_px[2];
            win_px[2][0] = top;
            win_px[2][1] = mid;
            win_px[2][2] = px;

            emitting = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            last_slot = (in_row == h + 1);
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end

            if (emitting)
            begin
                col_ok = {out_col + 1 < w, 1'b1, out_col > 0};
                row_ok = {out_row + 1 < h, 1'b1, out_row > 0};
                res.color.red = channel_mean(16, col_ok, row_ok);
                res.color.green = channel_mean(8, col_ok, row_ok);
                res.color.blue = channel_mean(0, col_ok, row_ok);
                res.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
                expected_pixels.push_back(res);
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end

            if (last_slot)
            begin
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(pix_t got, logic got_end);
            blur_out_t want;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %0d %0d %0d end %0d",
                         $time, got.red, got.green, got.blue, got_end);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("out_red", want.color.red, got.red);
            compare_field("out_green", want.color.green, got.green);
            compare_field("out_blue", want.color.blue, got.blue);
            compare_field("frame_end", want.frame_end, got_end);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   sink_ready;
    bit   source_idles;
    bit   sink_stalls;
    int   stall_left;
    int   cycle_count;
    int   sent_items;

    blur_scoreboard sb;

    bb3e_pix_if pix_bus ();
    bb3e_res_if res_bus ();
    bb3e_cfg_if cfg_bus ();

    assign res_bus.ready = sink_ready;

    box_blur_3x3_edge_aware u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .pixels  (pix_bus),
        .results (res_bus)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [7:0] chan_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic pix_t random_pixel();
        pix_t p;
        p.red = chan_value();
        p.green = chan_value();
        p.blue = chan_value();
        return p;
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (sink_stalls && $urandom_range(0, 3) == 0)
        begin
            sink_ready <= 1'b0;
            stall_left <= pick_gap() - 1;
        end
        else
            sink_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
            sb.check_result({res_bus.out_red, res_bus.out_green, res_bus.out_blue},
                            res_bus.frame_end);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_req(logic kind, pix_t p);
        int gap;
        gap = (source_idles && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.req_type <= kind;
        pix_bus.in_red <= p.red;
        pix_bus.in_green <= p.green;
        pix_bus.in_blue <= p.blue;
        do
            @(posedge clk);
        while (!pix_bus.ready);
        sb.note_request(kind, p);
        sent_items++;
    endtask

    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        sb.write_reg(idx, value);
    endtask

    task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, bit write_w, bit write_h);
        wait_idle();
        if (write_w)
            cfg_write(REG_IMAGE_WIDTH, w);
        if (write_h)
            cfg_write(REG_IMAGE_HEIGHT, h);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_frame(int noise_pct, int stop_after, int pause_at);
        int w;
        int h;
        int slots;
        w = sb.used_width();
        h = sb.used_height();
        slots = w * h + w + 1;
        for (int s = 0; s < slots && s < stop_after; s++)
        begin
            logic kind;
            kind = (s < w * h) ? REQ_PIXEL : REQ_DRAIN;
            if ($urandom_range(0, 99) < noise_pct)
                send_req((kind == REQ_PIXEL) ? REQ_DRAIN : REQ_PIXEL, random_pixel());
            if (s == pause_at)
                wait_idle();
            send_req(kind, random_pixel());
        end
    endtask

    task automatic run_directed();
        pix_t p;
        set_size(3, 3, 1'b1, 1'b1);
        for (int k = 0; k < 9; k++)
        begin
            p.red = (k % 2 == 1) ? 8'hFF : 8'h00;
            p.green = (k % 3 == 0) ? 8'hFF : 8'h01;
            p.blue = 8'(k * 37);
            if (k == 2)
                send_req(REQ_DRAIN, p);
            if (k == 5)
                wait_idle();
            send_req(REQ_PIXEL, p);
        end
        send_req(REQ_PIXEL, '1);
        for (int k = 0; k < 4; k++)
            send_req(REQ_DRAIN, '0);

        set_size(0, 0, 1'b1, 1'b1);
        send_req(REQ_PIXEL, '1);
        send_req(REQ_DRAIN, '1);
        send_req(REQ_DRAIN, '0);

        set_size(2, 1, 1'b1, 1'b1);
        send_req(REQ_PIXEL, '1);
        send_req(REQ_PIXEL, '0);
        for (int k = 0; k < 3; k++)
            send_req(REQ_DRAIN, '0);
    endtask

    task automatic run_random();
        bit partial;
        bit write_w;
        int w;
        int h;
        int slots;
        int stop_after;
        int pause_at;
        partial = 1'b0;
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            source_idles <= ($urandom_range(0, 2) != 0);
            sink_stalls <= ($urandom_range(0, 2) != 0);
            if (partial || $urandom_range(0, 1) == 0)
            begin
                w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
                h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
                write_w = 1'($urandom_range(0, 1));
                set_size(CFG_W'(w), CFG_W'(h), write_w, !write_w || $urandom_range(0, 1) == 1);
            end
            slots = sb.used_width() * sb.used_height() + sb.used_width() + 1;
            stop_after = ($urandom_range(0, 9) == 0) ? $urandom_range(1, slots - 1) : slots;
            pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, slots - 1) : -1;
            send_frame(5, stop_after, pause_at);
            partial = (stop_after < slots);
        end
    endtask

    task automatic run_extremes();
        int ext_w [4] = '{2047, 1024, 1, 2};
        int ext_h [4] = '{2047, 1, 2047, 1024};
        for (int k = 0; k < 4; k++)
        begin
            source_idles <= ($urandom_range(0, 1) == 1);
            sink_stalls <= ($urandom_range(0, 1) == 1);
            set_size(CFG_W'(ext_w[k]), CFG_W'(ext_h[k]), 1'b1, 1'b1);
            send_frame(2, EXTREME_SLOTS, -1);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cycle_count = 0;
        stall_left = 0;
        pix_bus.valid <= 1'b0;
        pix_bus.req_type <= REQ_PIXEL;
        pix_bus.in_red <= 8'h00;
        pix_bus.in_green <= 8'h00;
        pix_bus.in_blue <= 8'h00;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= REG_IMAGE_WIDTH;
        cfg_bus.data <= '0;
        source_idles <= 1'b0;
        sink_stalls <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();
        run_extremes();
        wait_idle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
design/bb3e_pkg.sv
design/bb3e_if.sv
design/bb3e_line_buf.sv
design/box_blur_3x3_edge_aware.sv
sim/box_blur_3x3_edge_aware_tb.sv
